/* rtl/catcd_pkg.sv */
// ----------------------------------------------------------------------------
// catcd_pkg
// Shared codes, character constants and the mnemonic table of the CAT
// command decoder.
// ----------------------------------------------------------------------------
package catcd_pkg;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ERR        = 3'd1;
   localparam logic [2:0] ST_REPORT     = 3'd2;
   localparam logic [2:0] ST_SILENT_OK  = 3'd3;
   localparam logic [2:0] ST_SILENT_ERR = 3'd4;

   // setting codes
   localparam logic [4:0] SET_NONE    = 5'd0;
   localparam logic [4:0] SET_AFC     = 5'd1;
   localparam logic [4:0] SET_CRC     = 5'd2;
   localparam logic [4:0] SET_ENC     = 5'd3;
   localparam logic [4:0] SET_RXRATE  = 5'd4;
   localparam logic [4:0] SET_TXRATE  = 5'd5;
   localparam logic [4:0] SET_FREQ    = 5'd6;
   localparam logic [4:0] SET_FRAMING = 5'd7;
   localparam logic [4:0] SET_RXFN    = 5'd8;
   localparam logic [4:0] SET_TXFN    = 5'd9;
   localparam logic [4:0] SET_AGC     = 5'd10;
   localparam logic [4:0] SET_IF      = 5'd11;
   localparam logic [4:0] SET_MOD     = 5'd12;
   localparam logic [4:0] SET_POWER   = 5'd13;
   localparam logic [4:0] SET_BW      = 5'd14;
   localparam logic [4:0] SET_RSSI    = 5'd15;
   localparam logic [4:0] SET_RFTRACK = 5'd16;

   // characters
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   // value scaling constants
   localparam int AGC_TOP      = 15;
   localparam int POWER_OFFSET = 10;

   // start positions of the decimal fields
   localparam int POS_FREQ  = 2;
   localparam int POS_VAL   = 3;
   localparam int POS_RSSI  = 4;
   localparam int POS_TRACK = 5;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_AGC,
      KIND_POWER,
      KIND_TXFN
   } kind_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] setting;
      logic [3:0] term;     // index of the terminating ';'
      kind_type   kind;
   } cmd_desc_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // radio-numbered setting commands
   function automatic cmd_desc_type cmd_lookup(input logic [15:0] mn);
      cmd_desc_type d;
      d = '{hit: 1'b1, setting: SET_NONE, term: 4'd4, kind: KIND_PLAIN};
      case (mn)
         "AF": begin d.setting = SET_AFC;     d.term = 4'd9; end
         "CT": begin d.setting = SET_CRC;     end
         "EM": begin d.setting = SET_ENC;     end
         "DR": begin d.setting = SET_RXRATE;  d.term = 4'd9; end
         "DT": begin d.setting = SET_TXRATE;  d.term = 4'd9; end
         "FM": begin d.setting = SET_FRAMING; end
         "FR": begin d.setting = SET_RXFN;    end
         "FT": begin d.setting = SET_TXFN;    d.kind = KIND_TXFN; end
         "GT": begin d.setting = SET_AGC;     d.term = 4'd5; d.kind = KIND_AGC; end
         "IS": begin d.setting = SET_IF;      d.term = 4'd9; end
         "MD": begin d.setting = SET_MOD;     end
         "PC": begin d.setting = SET_POWER;   d.term = 4'd5; d.kind = KIND_POWER; end
         default: begin
            d.hit = 1'b0;
         end
      endcase
      return d;
   endfunction

endpackage

/* rtl/catcd_digit_acc.sv */
// ----------------------------------------------------------------------------
// catcd_digit_acc
// Running decimal accumulator for a field that starts at a fixed byte
// position; tracks whether every byte seen so far is a digit.
// ----------------------------------------------------------------------------
module catcd_digit_acc #(
   parameter int START = 2,
   parameter int WIDTH = 30,
   parameter int POS_W = 4
) (
   input  logic             clock,
   input  logic             store_en,
   input  logic [POS_W-1:0] pos,
   input  logic [7:0]       rx_char,
   output logic [WIDTH-1:0] acc,
   output logic             all_digits
);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic             ok_ff, ok_in;
   logic             isd;
   logic [WIDTH-1:0] dig;

   assign isd = catcd_pkg::is_digit(rx_char);
   assign dig = WIDTH'(rx_char[3:0]);

   // first digit loads, later digits shift in by ten
   always_comb begin
      acc_in = acc_ff;
      ok_in  = ok_ff;
      if (store_en && pos == POS_W'(START)) begin
         acc_in = dig;
         ok_in  = isd;
      end else if (store_en && pos > POS_W'(START)) begin
         acc_in = {acc_ff[WIDTH-4:0], 3'b000} + {acc_ff[WIDTH-2:0], 1'b0} + dig;
         ok_in  = ok_ff & isd;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ok_ff  <= ok_in;
   end

   assign acc        = acc_ff;
   assign all_digits = ok_ff;

endmodule

/* rtl/cat_command_decoder.sv */
// ----------------------------------------------------------------------------
// cat_command_decoder
// ASCII CAT command decoder: buffers bytes up to ';' and emits one result.
// ----------------------------------------------------------------------------
// One byte is taken per clock. Decimal fields are accumulated as the bytes
// arrive, so the ';' byte is decoded in the cycle it is transferred and its
// result appears in the output register on the next cycle. Input stalls only
// while a result is held and the consumer is not ready. Bytes past the first
// CMD_BYTES of a command are dropped; the ';' still ends the command.
module cat_command_decoder #(
   parameter int CMD_BYTES = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [2:0] status, [7:3] setting, [8] radio,
                                    // [39:9] value
);

   localparam int CW   = $clog2(CMD_BYTES + 1);
   localparam int HEAD = 5;

   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [7:0]     head_ff [HEAD];
   logic [9:0]     rssi_ff [2];
   logic           rsp_valid_ff, rsp_valid_in;
   logic [39:0]    rsp_data_ff, rsp_data_in;

   logic           xfer, stored, is_semi, store_en;
   logic [7:0]     c0, c1, c2, c3, c4;
   logic [29:0]    acc_freq;
   logic [19:0]    acc_val, acc_track;
   logic [9:0]     acc_rssi;
   logic           ok_freq, ok_val, ok_rssi, ok_track;
   catcd_pkg::cmd_desc_type desc;

   logic [2:0]     st;
   logic [4:0]     set;
   logic           rad;
   logic [30:0]    val;
   logic           rssi_we;
   logic           r01;

   assign xfer       = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign stored     = cnt_ff < CW'(CMD_BYTES);
   assign is_semi    = req_tdata == catcd_pkg::CH_SEMI;
   assign store_en   = xfer && stored;

   function automatic logic [7:0] at_pos(input int i);
      if (CW'(i) < cnt_ff) return head_ff[i];
      if (CW'(i) == cnt_ff && stored) return req_tdata;
      return 8'h00;
   endfunction

   // ';' sits at index t when the current byte is stored there
   function automatic logic term_at(input logic [3:0] t);
      return stored && cnt_ff == CW'(t);
   endfunction

   // leading bytes of the command, current byte included
   always_comb begin
      c0 = at_pos(0);
      c1 = at_pos(1);
      c2 = at_pos(2);
      c3 = at_pos(3);
      c4 = at_pos(4);
   end

   // digit accumulators
   catcd_digit_acc #(.START(catcd_pkg::POS_FREQ), .WIDTH(30), .POS_W(CW)) u_acc_freq (
      .clock(clock), .store_en(store_en), .pos(cnt_ff), .rx_char(req_tdata),
      .acc(acc_freq), .all_digits(ok_freq));
   catcd_digit_acc #(.START(catcd_pkg::POS_VAL), .WIDTH(20), .POS_W(CW)) u_acc_val (
      .clock(clock), .store_en(store_en), .pos(cnt_ff), .rx_char(req_tdata),
      .acc(acc_val), .all_digits(ok_val));
   catcd_digit_acc #(.START(catcd_pkg::POS_RSSI), .WIDTH(10), .POS_W(CW)) u_acc_rssi (
      .clock(clock), .store_en(store_en), .pos(cnt_ff), .rx_char(req_tdata),
      .acc(acc_rssi), .all_digits(ok_rssi));
   catcd_digit_acc #(.START(catcd_pkg::POS_TRACK), .WIDTH(20), .POS_W(CW)) u_acc_track (
      .clock(clock), .store_en(store_en), .pos(cnt_ff), .rx_char(req_tdata),
      .acc(acc_track), .all_digits(ok_track));

   assign desc = catcd_pkg::cmd_lookup({c0, c1});
   assign r01  = (c2 == catcd_pkg::CH_ZERO) || (c2 == catcd_pkg::CH_ONE);

   // command decode
   always_comb begin
      st      = catcd_pkg::ST_ERR;
      set     = catcd_pkg::SET_NONE;
      rad     = 1'b0;
      val     = '0;
      rssi_we = 1'b0;
      if (desc.hit) begin
         if (r01 && term_at(desc.term) && ok_val) begin
            st  = catcd_pkg::ST_OK;
            set = desc.setting;
            rad = c2[0];
            case (desc.kind)
               catcd_pkg::KIND_AGC:
                  val = 31'(catcd_pkg::AGC_TOP) - {11'b0, acc_val};
               catcd_pkg::KIND_POWER:
                  val = {11'b0, acc_val} - 31'(catcd_pkg::POWER_OFFSET);
               catcd_pkg::KIND_TXFN: begin
                  val = {11'b0, acc_val};
                  if (acc_val > 20'd1) begin
                     st  = catcd_pkg::ST_SILENT_ERR;
                     set = catcd_pkg::SET_NONE;
                     rad = 1'b0;
                     val = '0;
                  end
               end
               default: val = {11'b0, acc_val};
            endcase
         end
      end else if ({c0, c1} == "FA" || {c0, c1} == "FB") begin
         if (term_at(4'd11) && ok_freq) begin
            st  = catcd_pkg::ST_OK;
            set = catcd_pkg::SET_FREQ;
            rad = (c1 == "B");
            val = {1'b0, acc_freq};
         end
      end else if ({c0, c1} == "RM") begin
         if (catcd_pkg::is_digit(c2) && catcd_pkg::is_digit(c3)) begin
            if (c3 == catcd_pkg::CH_ZERO) begin
               if (!term_at(4'd7)) begin
                  st = catcd_pkg::ST_SILENT_OK;
               end else if (ok_rssi && r01) begin
                  st      = catcd_pkg::ST_SILENT_OK;
                  set     = catcd_pkg::SET_RSSI;
                  rad     = c2[0];
                  val     = 31'd0 - {21'b0, acc_rssi};
                  rssi_we = 1'b1;
               end
            end else if (c3 == catcd_pkg::CH_ONE) begin
               if (!term_at(4'd11)) begin
                  st = catcd_pkg::ST_SILENT_OK;
               end else if (ok_track && r01 &&
                            (c4 == catcd_pkg::CH_PLUS || c4 == catcd_pkg::CH_MINUS)) begin
                  st  = catcd_pkg::ST_SILENT_OK;
                  set = catcd_pkg::SET_RFTRACK;
                  rad = c2[0];
                  val = (c4 == catcd_pkg::CH_MINUS) ? 31'd0 - {11'b0, acc_track}
                                                    : {11'b0, acc_track};
               end
            end
         end
      end else if ({c0, c1} == "SM") begin
         if (r01 && term_at(4'd3)) begin
            st  = catcd_pkg::ST_REPORT;
            set = catcd_pkg::SET_RSSI;
            rad = c2[0];
            val = {21'b0, rssi_ff[c2[0]]};
         end
      end else if ({c0, c1} == "DA" || {c0, c1} == "EX" || {c0, c1} == "KS" ||
                   {c0, c1} == "RG" || {c0, c1} == "TC") begin
         st = catcd_pkg::ST_SILENT_OK;
      end else if (c0 == "?" && c1 == catcd_pkg::CH_SEMI) begin
         st = catcd_pkg::ST_SILENT_ERR;
      end else if ({c0, c1} == "OK" && c2 == catcd_pkg::CH_SEMI) begin
         st = catcd_pkg::ST_SILENT_OK;
      end
   end

   // byte count
   always_comb begin
      cnt_in = cnt_ff;
      if (xfer) begin
         if (is_semi)     cnt_in = '0;
         else if (stored) cnt_in = cnt_ff + CW'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (xfer && is_semi) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {val, rad, set, st};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rssi_ff[0]   <= '0;
         rssi_ff[1]   <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (xfer && is_semi && rssi_we) rssi_ff[c2[0]] <= acc_rssi;
      end
   end

   // head bytes and result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < HEAD; i++) begin
         if (store_en && cnt_ff == CW'(i)) head_ff[i] <= req_tdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/catcd_checker.sv */
// ----------------------------------------------------------------------------
// catcd_checker
// Port-level assertions for the CAT command decoder, bound to the top level.
// ----------------------------------------------------------------------------
module catcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // an empty output side never blocks input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // every ';' transfer yields a result next cycle
   a_semi: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata == catcd_pkg::CH_SEMI |=> rsp_tvalid)
      else $error("missing result after terminator");

   // other bytes yield nothing
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata != catcd_pkg::CH_SEMI &&
      (!rsp_tvalid || rsp_tready) |=> !rsp_tvalid)
      else $error("result without terminator");

   // status code in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= catcd_pkg::ST_SILENT_ERR)
      else $error("bad status code");

endmodule

bind cat_command_decoder catcd_checker u_catcd_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
